>>> hw/rtl/imht_pkg.sv
// ----------------------------------------------------------------------------
// imht_pkg
// Shared types, codes and sizes of the image map area hit test core.
// ----------------------------------------------------------------------------
package imht_pkg;

  localparam int MAX_AREAS_DEF    = 16;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS       = 16;

  localparam logic [1:0] CMD_CLEAR      = 2'd0;
  localparam logic [1:0] CMD_ADD_AREA   = 2'd1;
  localparam logic [1:0] CMD_ADD_VERTEX = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  localparam logic [1:0] KIND_RECT   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_POLY   = 2'd2;

  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_AREA_FULL   = 2'd1;
  localparam logic [1:0] ST_VERTEX_FULL = 2'd2;
  localparam logic [1:0] ST_NO_POLY     = 2'd3;

  localparam logic [1:0] TITLE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]                   command;
    logic [1:0]                   shape;
    logic signed [COORD_BITS-1:0] coord_a;
    logic signed [COORD_BITS-1:0] coord_b;
    logic signed [COORD_BITS-1:0] coord_c;
    logic signed [COORD_BITS-1:0] coord_d;
    logic [1:0]                   title_mode;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [3:0] area_index;
    logic [1:0] title_result;
  } rsp_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_AREA_NEXT,
    OP_HIT,
    OP_POLY_START,
    OP_LOAD_J,
    OP_LOAD_I,
    OP_MUL_DX,
    OP_MUL_DY,
    OP_MUL_R,
    OP_MUL_LHS,
    OP_MUL_RHS,
    OP_EDGE_CMP,
    OP_EDGE_NEXT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic       is_query;
    logic       area_valid;
    logic [1:0] kind;
    logic       rect_hold;
    logic       circle_hold;
    logic       total_zero;
    logic       spans;
    logic       edges_last;
    logic       poly_in;
    logic       out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/image_map_area_hit_test_core.sv
// ----------------------------------------------------------------------------
// image_map_area_hit_test_core
// Ordered table of rectangle, circle and polygon areas with point hit test.
// ----------------------------------------------------------------------------
// Every request item gives one response item. Clear, add area and add vertex
// go from accept via the result state to the response register. A query walks
// the areas in add order through one shared 17x17 multiplier (circles: dx*dx,
// dy*dy, r*r; polygon edges spanning the query row: two products), stopping
// at the first hit; a miss is answered after the last area. A new request is
// taken once the previous one has reached the response register, which holds
// it until the receiver takes it.
module image_map_area_hit_test_core #(
  parameter int MAX_AREAS    = imht_pkg::MAX_AREAS_DEF,
  parameter int MAX_VERTICES = imht_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  imht_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output imht_pkg::rsp_item_t rsp
);

  imht_pkg::dp_op_t     op;
  imht_pkg::dp_status_t st;

  imht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .op        (op)
  );

  imht_dp #(
    .MAX_AREAS    (MAX_AREAS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .op        (op),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> hw/rtl/imht_dp.sv
// ----------------------------------------------------------------------------
// imht_dp
// Area table, vertex store, shared multiplier and result register.
// ----------------------------------------------------------------------------
module imht_dp #(
  parameter int MAX_AREAS    = imht_pkg::MAX_AREAS_DEF,
  parameter int MAX_VERTICES = imht_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  imht_pkg::req_item_t req,
  input  imht_pkg::dp_op_t    op,
  output imht_pkg::dp_status_t st,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output imht_pkg::rsp_item_t rsp
);

  localparam int CB   = imht_pkg::COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int AW   = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int ACW  = $clog2(MAX_AREAS + 1);
  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);

  logic [1:0]           kind_mem  [MAX_AREAS];
  logic signed [CB-1:0] ba_mem    [MAX_AREAS];
  logic signed [CB-1:0] bb_mem    [MAX_AREAS];
  logic signed [CB-1:0] bc_mem    [MAX_AREAS];
  logic signed [CB-1:0] bd_mem    [MAX_AREAS];
  logic [VCW-1:0]       first_mem [MAX_AREAS];
  logic [VCW-1:0]       total_mem [MAX_AREAS];
  logic [1:0]           title_mem [MAX_AREAS];
  logic signed [CB-1:0] vx_mem    [MAX_VERTICES];
  logic signed [CB-1:0] vy_mem    [MAX_VERTICES];

  logic [1:0]           kind_q;
  logic signed [CB-1:0] ba_q, bb_q, bc_q, bd_q;
  logic [VCW-1:0]       first_q, total_q;
  logic [1:0]           title_q;
  logic signed [CB-1:0] vx_q, vy_q;

  logic [ACW-1:0]       areas_used;
  logic [VCW-1:0]       vertices_used;
  logic                 open_poly;
  logic [VCW-1:0]       cur_total;
  logic [ACW-1:0]       aptr;
  logic [VW-1:0]        vaddr;
  logic [VCW-1:0]       cnt;
  logic                 poly_in;
  logic signed [CB-1:0] qx, qy, xi, yi, xj, yj;
  logic signed [DW-1:0] h_r;
  logic                 spans_r;
  logic signed [SW-1:0] acc, rr;
  logic [1:0]           res_status;
  logic                 res_hit;
  logic [3:0]           res_index;
  logic [1:0]           res_title;

  logic                 add_ok, vtx_ok;
  logic [1:0]           acc_status;
  logic [ACW-1:0]       last_area;
  logic [VCW-1:0]       new_total;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic                 spans;
  logic signed [DW-1:0] h;
  logic                 edge_left;

  assign add_ok = (op == imht_pkg::OP_ACCEPT) && (req.command == imht_pkg::CMD_ADD_AREA) &&
                  (req.shape <= imht_pkg::KIND_POLY) && (areas_used < ACW'(MAX_AREAS));
  assign vtx_ok = (op == imht_pkg::OP_ACCEPT) && (req.command == imht_pkg::CMD_ADD_VERTEX) &&
                  open_poly && (vertices_used < VCW'(MAX_VERTICES));
  assign last_area = areas_used - ACW'(1);
  assign new_total = cur_total + VCW'(1);

  always_comb begin
    priority if ((req.command == imht_pkg::CMD_ADD_AREA) &&
                 (req.shape <= imht_pkg::KIND_POLY) && (areas_used >= ACW'(MAX_AREAS))) begin
      acc_status = imht_pkg::ST_AREA_FULL;
    end else if ((req.command == imht_pkg::CMD_ADD_VERTEX) && !open_poly) begin
      acc_status = imht_pkg::ST_NO_POLY;
    end else if ((req.command == imht_pkg::CMD_ADD_VERTEX) &&
                 (vertices_used >= VCW'(MAX_VERTICES))) begin
      acc_status = imht_pkg::ST_VERTEX_FULL;
    end else begin
      acc_status = imht_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      kind_mem[areas_used[AW-1:0]]  <= req.shape;
      ba_mem[areas_used[AW-1:0]]    <= req.coord_a;
      bb_mem[areas_used[AW-1:0]]    <= req.coord_b;
      bc_mem[areas_used[AW-1:0]]    <= req.coord_c;
      bd_mem[areas_used[AW-1:0]]    <= req.coord_d;
      first_mem[areas_used[AW-1:0]] <= vertices_used;
      title_mem[areas_used[AW-1:0]] <= req.title_mode;
    end
    if (add_ok) begin
      total_mem[areas_used[AW-1:0]] <= '0;
    end else if (vtx_ok) begin
      total_mem[last_area[AW-1:0]] <= new_total;
    end
    kind_q  <= kind_mem[aptr[AW-1:0]];
    ba_q    <= ba_mem[aptr[AW-1:0]];
    bb_q    <= bb_mem[aptr[AW-1:0]];
    bc_q    <= bc_mem[aptr[AW-1:0]];
    bd_q    <= bd_mem[aptr[AW-1:0]];
    first_q <= first_mem[aptr[AW-1:0]];
    total_q <= total_mem[aptr[AW-1:0]];
    title_q <= title_mem[aptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vtx_ok) begin
      vx_mem[vertices_used[VW-1:0]] <= req.coord_a;
      vy_mem[vertices_used[VW-1:0]] <= req.coord_b;
    end
    vx_q <= vx_mem[vaddr];
    vy_q <= vy_mem[vaddr];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      imht_pkg::OP_MUL_DX: begin
        mul_a = DW'(qx) - DW'(ba_q);
        mul_b = mul_a;
      end
      imht_pkg::OP_MUL_DY: begin
        mul_a = DW'(qy) - DW'(bb_q);
        mul_b = mul_a;
      end
      imht_pkg::OP_MUL_R: begin
        mul_a = DW'(bc_q);
        mul_b = DW'(bc_q);
      end
      imht_pkg::OP_MUL_LHS: begin
        mul_a = DW'(qx) - DW'(xi);
        mul_b = h_r;
      end
      imht_pkg::OP_MUL_RHS: begin
        mul_a = DW'(xj) - DW'(xi);
        mul_b = DW'(qy) - DW'(yi);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign spans     = ((vy_q <= qy) && (qy < yj)) || ((yj <= qy) && (qy < vy_q));
  assign h         = DW'(yj) - DW'(vy_q);
  assign edge_left = (h_r > 0) ? (acc < rr) : (acc > rr);

  always_comb begin
    st.is_query    = (req.command == imht_pkg::CMD_QUERY);
    st.area_valid  = (aptr < areas_used);
    st.kind        = kind_q;
    st.rect_hold   = (qx >= ba_q) && (qx < bc_q) && (qy >= bb_q) && (qy < bd_q);
    st.circle_hold = (acc < rr);
    st.total_zero  = (total_q == '0);
    st.spans       = spans_r;
    st.edges_last  = (cnt == VCW'(1));
    st.poly_in     = poly_in;
    st.out_free    = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      areas_used    <= '0;
      vertices_used <= '0;
      open_poly     <= 1'b0;
      aptr          <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (op != imht_pkg::OP_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (op)
        imht_pkg::OP_ACCEPT: begin
          res_status <= acc_status;
          res_hit    <= 1'b0;
          res_index  <= '0;
          res_title  <= (req.command == imht_pkg::CMD_QUERY) ? imht_pkg::TITLE_NONE : 2'd0;
          unique case (req.command)
            imht_pkg::CMD_CLEAR: begin
              areas_used    <= '0;
              vertices_used <= '0;
              open_poly     <= 1'b0;
            end
            imht_pkg::CMD_ADD_AREA: begin
              if (add_ok) begin
                areas_used <= areas_used + ACW'(1);
                open_poly  <= (req.shape == imht_pkg::KIND_POLY);
                cur_total  <= '0;
              end
            end
            imht_pkg::CMD_ADD_VERTEX: begin
              if (vtx_ok) begin
                vertices_used <= vertices_used + VCW'(1);
                cur_total     <= new_total;
              end
            end
            imht_pkg::CMD_QUERY: begin
              qx   <= req.coord_a;
              qy   <= req.coord_b;
              aptr <= '0;
            end
            default: begin
            end
          endcase
        end
        imht_pkg::OP_AREA_NEXT: aptr <= aptr + ACW'(1);
        imht_pkg::OP_HIT: begin
          res_hit   <= 1'b1;
          res_index <= 4'(aptr);
          res_title <= title_q;
        end
        imht_pkg::OP_POLY_START: begin
          vaddr   <= VW'(first_q + total_q - VCW'(1));
          cnt     <= total_q;
          poly_in <= 1'b0;
        end
        imht_pkg::OP_LOAD_J: begin
          xj    <= vx_q;
          yj    <= vy_q;
          vaddr <= VW'(first_q);
        end
        imht_pkg::OP_LOAD_I: begin
          xi      <= vx_q;
          yi      <= vy_q;
          spans_r <= spans;
          h_r     <= h;
        end
        imht_pkg::OP_MUL_DX:  acc <= SW'(prod);
        imht_pkg::OP_MUL_DY:  acc <= acc + SW'(prod);
        imht_pkg::OP_MUL_R:   rr  <= SW'(prod);
        imht_pkg::OP_MUL_LHS: acc <= SW'(prod);
        imht_pkg::OP_MUL_RHS: rr  <= SW'(prod);
        imht_pkg::OP_EDGE_CMP: begin
          if (edge_left) begin
            poly_in <= !poly_in;
          end
        end
        imht_pkg::OP_EDGE_NEXT: begin
          xj    <= xi;
          yj    <= yi;
          cnt   <= cnt - VCW'(1);
          vaddr <= vaddr + VW'(1);
        end
        imht_pkg::OP_OUT: begin
          rsp_valid        <= 1'b1;
          rsp.status       <= res_status;
          rsp.hit          <= res_hit;
          rsp.area_index   <= res_index;
          rsp.title_result <= res_title;
        end
        imht_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_areas_bound: assert property (@(posedge clk) disable iff (rst)
    areas_used <= ACW'(MAX_AREAS)) else $error("area count overflow");
  a_vertices_bound: assert property (@(posedge clk) disable iff (rst)
    vertices_used <= VCW'(MAX_VERTICES)) else $error("vertex count overflow");
  a_open_poly: assert property (@(posedge clk) disable iff (rst)
    open_poly |-> (areas_used != '0)) else $error("open polygon with empty table");
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (op == imht_pkg::OP_ACCEPT) && (req.command == imht_pkg::CMD_QUERY) |=>
    (aptr == '0) && (res_title == imht_pkg::TITLE_NONE) && !res_hit)
    else $error("query did not start at first area");

endmodule

>>> hw/rtl/imht_ctrl.sv
// ----------------------------------------------------------------------------
// imht_ctrl
// Sequencer for command execution and the area / edge walk of a query.
// ----------------------------------------------------------------------------
module imht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  imht_pkg::dp_status_t st,
  output imht_pkg::dp_op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA_RD,
    S_AREA_EVAL,
    S_C_DY,
    S_C_R,
    S_C_CMP,
    S_P_RDJ,
    S_P_LDJ,
    S_P_RDI,
    S_P_LDI,
    S_P_TEST,
    S_P_RHS,
    S_P_CMP,
    S_P_ADV,
    S_P_END,
    S_RESULT
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = imht_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op         = imht_pkg::OP_ACCEPT;
          state_next = st.is_query ? S_AREA_RD : S_RESULT;
        end
      end
      S_AREA_RD: state_next = st.area_valid ? S_AREA_EVAL : S_RESULT;
      S_AREA_EVAL: begin
        unique case (st.kind)
          imht_pkg::KIND_RECT: begin
            op         = st.rect_hold ? imht_pkg::OP_HIT : imht_pkg::OP_AREA_NEXT;
            state_next = st.rect_hold ? S_RESULT : S_AREA_RD;
          end
          imht_pkg::KIND_CIRCLE: begin
            op         = imht_pkg::OP_MUL_DX;
            state_next = S_C_DY;
          end
          imht_pkg::KIND_POLY: begin
            op         = st.total_zero ? imht_pkg::OP_AREA_NEXT : imht_pkg::OP_POLY_START;
            state_next = st.total_zero ? S_AREA_RD : S_P_RDJ;
          end
          default: begin
            op         = imht_pkg::OP_AREA_NEXT;
            state_next = S_AREA_RD;
          end
        endcase
      end
      S_C_DY: begin
        op         = imht_pkg::OP_MUL_DY;
        state_next = S_C_R;
      end
      S_C_R: begin
        op         = imht_pkg::OP_MUL_R;
        state_next = S_C_CMP;
      end
      S_C_CMP: begin
        op         = st.circle_hold ? imht_pkg::OP_HIT : imht_pkg::OP_AREA_NEXT;
        state_next = st.circle_hold ? S_RESULT : S_AREA_RD;
      end
      S_P_RDJ: state_next = S_P_LDJ;
      S_P_LDJ: begin
        op         = imht_pkg::OP_LOAD_J;
        state_next = S_P_RDI;
      end
      S_P_RDI: state_next = S_P_LDI;
      S_P_LDI: begin
        op         = imht_pkg::OP_LOAD_I;
        state_next = S_P_TEST;
      end
      S_P_TEST: begin
        if (st.spans) begin
          op         = imht_pkg::OP_MUL_LHS;
          state_next = S_P_RHS;
        end else begin
          op         = imht_pkg::OP_EDGE_NEXT;
          state_next = st.edges_last ? S_P_END : S_P_RDI;
        end
      end
      S_P_RHS: begin
        op         = imht_pkg::OP_MUL_RHS;
        state_next = S_P_CMP;
      end
      S_P_CMP: begin
        op         = imht_pkg::OP_EDGE_CMP;
        state_next = S_P_ADV;
      end
      S_P_ADV: begin
        op         = imht_pkg::OP_EDGE_NEXT;
        state_next = st.edges_last ? S_P_END : S_P_RDI;
      end
      S_P_END: begin
        op         = st.poly_in ? imht_pkg::OP_HIT : imht_pkg::OP_AREA_NEXT;
        state_next = st.poly_in ? S_RESULT : S_AREA_RD;
      end
      S_RESULT: begin
        if (st.out_free) begin
          op         = imht_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
